@@ src/dhps_pkg.sv @@
// types, codes and helpers shared by the haptic pattern sequencer
`default_nettype none

package dhps_pkg;

	localparam int STORE_DEPTH   = 64;
	localparam int DURATION_BITS = 16;
	localparam int ADDR_W        = $clog2(STORE_DEPTH);
	localparam int SUM_W         = 8;

	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [DURATION_BITS-1:0] dur_t;
	typedef logic [7:0]               str_t;
	typedef logic [5:0]               start_t;
	typedef logic [6:0]               count_t;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_LOAD = 2'd1,
		MODE_PLAY = 2'd2,
		MODE_STOP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SEL_LEFT  = 2'd0,
		SEL_RIGHT = 2'd1,
		SEL_BOTH  = 2'd2,
		SEL_NONE  = 2'd3
	} sel_t;

	typedef struct packed {
		mode_t       mode;
		sel_t        channel_select;
		logic [5:0]  step_address;
		logic [6:0]  pattern_steps;
		logic [7:0]  step_strength;
		logic [15:0] step_duration;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] left_strength;
		logic [7:0] right_strength;
		logic       left_busy;
		logic       right_busy;
	} rsp_word_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		str_t  strength;
		dur_t  duration;
	} store_wr_t;

	typedef struct packed {
		logic   tick;
		logic   play;
		logic   stop;
		start_t start;
		count_t count;
	} chan_cmd_t;

	typedef struct packed {
		str_t level;
		logic busy;
	} chan_stat_t;

	// store entry of a pattern step, wrapping round the store
	function automatic addr_t entry_addr(input start_t start, input count_t offset);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(start) + SUM_W'(offset);
		return addr_t'(sum);
	endfunction

endpackage

`default_nettype wire

@@ src/dhps_ram.sv @@
// generic step store copy: one write port, one registered write-first read port
`default_nettype none

module dhps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/dhps_chan.sv @@
// one motor channel: pattern state, step timer and its own store copies
`default_nettype none

module dhps_chan import dhps_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_wr_t  wr,
	input  wire chan_cmd_t  cmd,
	input  wire str_t       play_str,
	output chan_stat_t      stat
);

	start_t start_q, start_d;
	count_t len_q, len_d;
	count_t off_q, off_d;
	dur_t   elapsed_q, elapsed_d;
	logic   active_q, active_d;
	str_t   level_q, level_d;

	dur_t   cur_dur;
	str_t   next_str;
	dur_t   elapsed_inc;
	count_t off_inc;

	// current step's duration and following step's strength, read for the next state
	dhps_ram #(.WIDTH(DURATION_BITS), .DEPTH(STORE_DEPTH)) u_dur_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.duration),
		.re    (1'b1),
		.raddr (entry_addr(start_d, off_d)),
		.rdata (cur_dur)
	);

	dhps_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_str_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.strength),
		.re    (1'b1),
		.raddr (entry_addr(start_d, off_d + 7'd1)),
		.rdata (next_str)
	);

	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + dur_t'(1);
	assign off_inc     = off_q + 7'd1;

	always_comb begin
		start_d   = start_q;
		len_d     = len_q;
		off_d     = off_q;
		elapsed_d = elapsed_q;
		active_d  = active_q;
		level_d   = level_q;
		if (cmd.play) begin
			start_d   = cmd.start;
			len_d     = (cmd.count == '0) ? 7'd1 : cmd.count;
			off_d     = '0;
			elapsed_d = '0;
			active_d  = 1'b1;
			level_d   = play_str;
		end else if (cmd.stop) begin
			active_d = 1'b0;
			level_d  = '0;
		end else if (cmd.tick && active_q) begin
			if (elapsed_inc >= cur_dur) begin
				off_d     = off_inc;
				elapsed_d = '0;
				if (off_inc >= len_q) begin
					active_d = 1'b0;
					level_d  = '0;
				end else begin
					level_d = next_str;
				end
			end else begin
				elapsed_d = elapsed_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= '0;
			len_q     <= '0;
			off_q     <= '0;
			elapsed_q <= '0;
			active_q  <= 1'b0;
			level_q   <= '0;
		end else begin
			start_q   <= start_d;
			len_q     <= len_d;
			off_q     <= off_d;
			elapsed_q <= elapsed_d;
			active_q  <= active_d;
			level_q   <= level_d;
		end
	end

	assign stat.level = level_d;
	assign stat.busy  = active_d;

	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> level_q == '0)
		else $error("idle channel drives nonzero strength");

	a_offset_in_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (off_q < len_q) && (len_q != '0))
		else $error("active channel beyond its pattern");

	a_play_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.play |=> active_q && off_q == '0 && elapsed_q == '0)
		else $error("play did not restart channel");

endmodule

`default_nettype wire

@@ src/dual_haptic_pattern_sequencer_top.sv @@
// top level of the two-channel haptic pattern sequencer
//
//  channel   dir  handshake            word
//  cmd       in   cmd_valid/cmd_stall  cmd_word_t: mode, select, address, count, strength, duration
//  rsp       out  rsp_valid/rsp_stall  rsp_word_t: left/right strength, left/right busy
//
//  one word per cycle while rsp_stall is low; an accepted word goes to stage 1, then its result to rsp
//  the word is registered in stage 1, the play copy of the store is read on the same edge
//  five copies of the 64-entry store (play, two per channel), all written by each load
//  arst_n clears the channel state and the valid flags; the store is not cleared
//  rsp_stall holds the result register; cmd_stall rises only when stage 1 is also full
`default_nettype none

module dual_haptic_pattern_sequencer_top import dhps_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_word_t cmd_data,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_word_t      rsp_data
);

	logic       valid_s1;
	cmd_word_t  cmd_s1;
	logic       rsp_valid_q;
	rsp_word_t  rsp_q;

	logic       s1_go;
	logic       cmd_accept;
	logic       hit_left;
	logic       hit_right;
	store_wr_t  wr;
	chan_cmd_t  cmd_left;
	chan_cmd_t  cmd_right;
	chan_stat_t stat_left;
	chan_stat_t stat_right;
	str_t       play_str;

	assign s1_go      = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign cmd_stall  = valid_s1 && !s1_go;
	assign cmd_accept = cmd_valid && !cmd_stall;

	assign hit_left  = (cmd_s1.channel_select == SEL_LEFT)
		|| (cmd_s1.channel_select == SEL_BOTH);
	assign hit_right = (cmd_s1.channel_select == SEL_RIGHT)
		|| (cmd_s1.channel_select == SEL_BOTH);

	assign wr.en       = s1_go && (cmd_s1.mode == MODE_LOAD);
	assign wr.addr     = addr_t'(cmd_s1.step_address);
	assign wr.strength = cmd_s1.step_strength;
	assign wr.duration = dur_t'(cmd_s1.step_duration);

	assign cmd_left.tick   = s1_go && (cmd_s1.mode == MODE_TICK);
	assign cmd_left.play   = s1_go && (cmd_s1.mode == MODE_PLAY) && hit_left;
	assign cmd_left.stop   = s1_go && (cmd_s1.mode == MODE_STOP) && hit_left;
	assign cmd_left.start  = cmd_s1.step_address;
	assign cmd_left.count  = cmd_s1.pattern_steps;

	assign cmd_right.tick  = s1_go && (cmd_s1.mode == MODE_TICK);
	assign cmd_right.play  = s1_go && (cmd_s1.mode == MODE_PLAY) && hit_right;
	assign cmd_right.stop  = s1_go && (cmd_s1.mode == MODE_STOP) && hit_right;
	assign cmd_right.start = cmd_s1.step_address;
	assign cmd_right.count = cmd_s1.pattern_steps;

	// first-step strength, read as the word enters stage 1
	dhps_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_play_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.strength),
		.re    (cmd_accept),
		.raddr (addr_t'(cmd_data.step_address)),
		.rdata (play_str)
	);

	dhps_chan u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.cmd      (cmd_left),
		.play_str (play_str),
		.stat     (stat_left)
	);

	dhps_chan u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.cmd      (cmd_right),
		.play_str (play_str),
		.stat     (stat_right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			rsp_valid_q <= s1_go || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			cmd_s1 <= cmd_data;
		end
		if (s1_go) begin
			rsp_q.left_strength  <= stat_left.level;
			rsp_q.right_strength <= stat_right.level;
			rsp_q.left_busy      <= stat_left.busy;
			rsp_q.right_busy     <= stat_right.busy;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && rsp_valid_q && rsp_stall)
		else $error("input stalled with room to take a word");

	a_accept_frees_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_accept && valid_s1) |-> s1_go)
		else $error("stage 1 overwritten before it moved on");

	a_go_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |=> rsp_valid)
		else $error("processed word gave no result");

endmodule

`default_nettype wire
